/* sv/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is off while reset is asserted
`define CHK_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that also runs during reset
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/grii_pkg.sv */
package grii_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int TIME_W      = 48;
    localparam int RATE_W      = 32;
    localparam int ROT_W       = 40;
    localparam int RATIO_W     = 24;
    localparam int STEP_W      = $clog2(RATIO_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ROTS_W      = 3 * ROT_W;
    localparam logic [1:0] LAST_AXIS = 2'd2;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                      kind;
        logic [TIME_W-1:0]        time_stamp;
        logic [TIME_W-1:0]        scan_end_time;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMP_MUL,
        ST_SAMP_ADD,
        ST_SAMP_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FETCH_RD,
        ST_FETCH_F,
        ST_FETCH_B,
        ST_DIV,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_OUT
    } back_state_t;

endpackage

/* sv/gyro_rotation_integrate_interpolate.sv */
// Back end takes one command at a time, the next in the cycle after the last ends.
// Start scan, anchor or dropped sample: handled in the idle state; appended sample: multiply and
// add for each axis, then a table write. Query: accept, then a halving search when time-ordered
// (linear once sample times went backward), then fetch front and out, or fetch front and back,
// divide, interpolate each axis and out; under two entries straight to out. Two-entry input queue.
// Synchronous active-low reset empties the table and queue; no clearing pass is needed.
module gyro_rotation_integrate_interpolate (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [grii_pkg::TIME_W-1:0]        s_time_stamp,
    input  logic [grii_pkg::TIME_W-1:0]        s_scan_end_time,
    input  logic signed [grii_pkg::RATE_W-1:0] s_rate_x,
    input  logic signed [grii_pkg::RATE_W-1:0] s_rate_y,
    input  logic signed [grii_pkg::RATE_W-1:0] s_rate_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [grii_pkg::ROT_W-1:0]  m_rot_x,
    output logic signed [grii_pkg::ROT_W-1:0]  m_rot_y,
    output logic signed [grii_pkg::ROT_W-1:0]  m_rot_z,
    output logic                               m_rotation_valid
);

    logic           cmd_valid;
    logic           cmd_ready;
    grii_pkg::cmd_t cmd;

    grii_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_time_stamp    (s_time_stamp),
        .s_scan_end_time (s_scan_end_time),
        .s_rate_x        (s_rate_x),
        .s_rate_y        (s_rate_y),
        .s_rate_z        (s_rate_z),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd)
    );

    grii_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rot_x          (m_rot_x),
        .m_rot_y          (m_rot_y),
        .m_rot_z          (m_rot_z),
        .m_rotation_valid (m_rotation_valid)
    );

endmodule

/* sv/grii_ram.sv */
module grii_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/grii_front.sv */
module grii_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [grii_pkg::TIME_W-1:0]        s_time_stamp,
    input  logic [grii_pkg::TIME_W-1:0]        s_scan_end_time,
    input  logic signed [grii_pkg::RATE_W-1:0] s_rate_x,
    input  logic signed [grii_pkg::RATE_W-1:0] s_rate_y,
    input  logic signed [grii_pkg::RATE_W-1:0] s_rate_z,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output grii_pkg::cmd_t                     cmd
);

    grii_pkg::cmd_t                    buf_reg [grii_pkg::QUEUE_DEPTH];
    logic [grii_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [grii_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [grii_pkg::QCNT_W-1:0]       fill_reg;
    logic [grii_pkg::QCNT_W-1:0]       fill_next;
    logic                              op_known;
    logic                              push;
    logic                              pop;
    grii_pkg::cmd_t                    in_cmd;

    // classify the operation code; unknown codes are taken and dropped
    always_comb begin
        case (s_operation)
            grii_pkg::OP_START,
            grii_pkg::OP_SAMPLE,
            grii_pkg::OP_QUERY: op_known = 1'b1;
            default:            op_known = 1'b0;
        endcase
    end

    always_comb begin
        in_cmd.kind          = grii_pkg::op_t'(s_operation);
        in_cmd.time_stamp    = s_time_stamp;
        in_cmd.scan_end_time = s_scan_end_time;
        in_cmd.rate_x        = s_rate_x;
        in_cmd.rate_y        = s_rate_y;
        in_cmd.rate_z        = s_rate_z;
    end

    assign s_ready   = (fill_reg != grii_pkg::QCNT_W'(grii_pkg::QUEUE_DEPTH));
    assign push      = s_valid && s_ready && op_known;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = buf_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* sv/grii_back.sv */
module grii_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  grii_pkg::cmd_t                    cmd,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [grii_pkg::ROT_W-1:0] m_rot_x,
    output logic signed [grii_pkg::ROT_W-1:0] m_rot_y,
    output logic signed [grii_pkg::ROT_W-1:0] m_rot_z,
    output logic                              m_rotation_valid
);

    localparam int AW  = grii_pkg::ADDR_W;
    localparam int CW  = grii_pkg::CNT_W;
    localparam int TW  = grii_pkg::TIME_W;
    localparam int RW  = grii_pkg::ROT_W;
    localparam int QW  = grii_pkg::RATIO_W;

    grii_pkg::back_state_t state_reg, state_next;

    // table bookkeeping
    logic [CW-1:0]        count_reg;
    logic [TW-1:0]        win_start_reg;
    logic [TW-1:0]        win_end_reg;
    logic [TW-1:0]        last_time_reg;
    logic signed [RW-1:0] last_rot_reg [3];
    logic                 sorted_reg;

    // working registers
    grii_pkg::cmd_t       cmd_reg;
    logic [TW-1:0]        dt_reg;
    logic [1:0]           axis_reg;
    logic [55:0]          phi_reg;
    logic [55:0]          plo_reg;
    logic signed [RW-1:0] new_rot_reg [3];
    logic [CW-1:0]        lo_reg;
    logic [CW-1:0]        hi_reg;
    logic [AW-1:0]        mid_reg;
    logic [AW-1:0]        f_reg;
    logic [TW-1:0]        ftime_reg;
    logic signed [RW-1:0] frot_reg [3];
    logic signed [RW-1:0] brot_reg [3];
    logic [TW-1:0]        rem_reg;
    logic [TW-1:0]        den_reg;
    logic [QW-1:0]        quo_reg;
    logic [grii_pkg::STEP_W-1:0] step_reg;
    logic [RW+QW:0]       lprod_reg;
    logic                 dneg_reg;
    logic signed [RW-1:0] res_rot_reg [3];
    logic                 res_valid_reg;
    logic                 m_valid_reg;
    logic signed [RW-1:0] m_rot_reg [3];
    logic                 m_rv_reg;

    // memory ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [TW-1:0]         ram_wtime;
    logic [grii_pkg::ROTS_W-1:0] ram_wrot;
    logic [AW-1:0]         ram_raddr;
    logic [TW-1:0]         ram_rtime;
    logic [grii_pkg::ROTS_W-1:0] ram_rrot;
    logic signed [RW-1:0]  rd_rot [3];

    // decode helpers
    logic                 pop;
    logic [TW-1:0]        in_t;
    logic                 samp_anchor;
    logic                 samp_first;
    logic                 samp_append;
    logic                 table_full;
    logic                 out_free;
    logic                 search_done;
    logic [CW:0]          mid_sum;
    logic [AW-1:0]        mid_sel;
    logic [AW-1:0]        f_sel;
    logic                 front_direct;

    // integration datapath
    logic signed [grii_pkg::RATE_W-1:0] rate_sel;
    logic [grii_pkg::RATE_W-1:0]        rate_mag;
    logic [55:0]          phi_calc;
    logic [55:0]          plo_calc;
    logic                 mag_over;
    logic [49:0]          mag_raw;
    logic [41:0]          mag;
    logic signed [42:0]   prev43;
    logic signed [42:0]   mag43;
    logic signed [42:0]   sum43;
    logic signed [RW-1:0] sat_rot;

    // division and interpolation datapath
    logic [TW:0]          rem2;
    logic                 rem_ge;
    logic [TW-1:0]        rem_step;
    logic signed [RW:0]   d41;
    logic [RW:0]          dmag;
    logic [RW+QW:0]       lprod_calc;
    logic [RW+QW:0]       lrnd;
    logic [RW:0]          adj;
    logic signed [RW:0]   back41;
    logic signed [RW:0]   res41;

    localparam logic [55:0]  PH_LIMIT  = 56'h100_0000_0000;
    localparam logic [49:0]  MAG_LIMIT = 50'h200_0000_0000;
    localparam logic [55:0]  HALF16    = 56'h8000;
    localparam logic [RW+QW:0] HALF_Q  = (RW+QW+1)'(1) << (QW - 1);
    localparam logic signed [42:0] SAT_MAX = 43'sh07F_FFFF_FFFF;
    localparam logic signed [42:0] SAT_MIN = -43'sh080_0000_0000;

    grii_ram #(.WIDTH(TW), .DEPTH(grii_pkg::TABLE_DEPTH)) u_time_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wtime),
        .rd_addr (ram_raddr),
        .rd_data (ram_rtime)
    );

    grii_ram #(.WIDTH(grii_pkg::ROTS_W), .DEPTH(grii_pkg::TABLE_DEPTH)) u_rot_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wrot),
        .rd_addr (ram_raddr),
        .rd_data (ram_rrot)
    );

    assign rd_rot[0] = ram_rrot[RW-1:0];
    assign rd_rot[1] = ram_rrot[2*RW-1:RW];
    assign rd_rot[2] = ram_rrot[3*RW-1:2*RW];

    // sample classification against the window and the table
    assign in_t        = cmd.time_stamp;
    assign table_full  = (count_reg >= CW'(grii_pkg::TABLE_DEPTH));
    assign samp_first  = (in_t < win_start_reg) || (count_reg == '0);
    assign samp_anchor = samp_first && !(in_t > win_end_reg);
    assign samp_append = !samp_first && !(in_t > win_end_reg) && !table_full;
    assign pop         = cmd_valid && (state_reg == grii_pkg::ST_IDLE);
    assign out_free    = !m_valid_reg || m_ready;

    // search step: halving on a sorted table, linear otherwise
    assign search_done = (lo_reg == hi_reg);
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_sel     = sorted_reg ? mid_sum[AW:1] : lo_reg[AW-1:0];
    assign f_sel       = (lo_reg == count_reg) ? AW'(count_reg - 1'b1) : lo_reg[AW-1:0];
    assign front_direct = (f_reg == '0) || (ram_rtime <= cmd_reg.time_stamp);

    // rate times step, one axis at a time
    always_comb begin
        case (axis_reg)
            2'd0:    rate_sel = cmd_reg.rate_x;
            2'd1:    rate_sel = cmd_reg.rate_y;
            default: rate_sel = cmd_reg.rate_z;
        endcase
    end

    assign rate_mag = rate_sel[grii_pkg::RATE_W-1] ? (~rate_sel + 1'b1) : rate_sel;
    assign phi_calc = 56'(rate_mag) * 56'(dt_reg[TW-1:24]);
    assign plo_calc = 56'(rate_mag) * 56'(dt_reg[23:0]);

    assign mag_over = (phi_reg > PH_LIMIT);
    assign mag_raw  = {phi_reg[41:0], 8'b0} + 50'((plo_reg + HALF16) >> 16);
    assign mag      = (mag_over || (mag_raw > MAG_LIMIT)) ? 42'(MAG_LIMIT) : mag_raw[41:0];
    assign prev43   = 43'(last_rot_reg[axis_reg]);
    assign mag43    = $signed({1'b0, mag});
    assign sum43    = rate_sel[grii_pkg::RATE_W-1] ? (prev43 - mag43) : (prev43 + mag43);

    // saturate to the rotation range
    always_comb begin
        if (sum43 > SAT_MAX) begin
            sat_rot = SAT_MAX[RW-1:0];
        end else if (sum43 < SAT_MIN) begin
            sat_rot = SAT_MIN[RW-1:0];
        end else begin
            sat_rot = sum43[RW-1:0];
        end
    end

    // restoring division step for the ratio
    assign rem2     = {rem_reg, 1'b0};
    assign rem_ge   = (rem2 >= {1'b0, den_reg});
    assign rem_step = rem_ge ? TW'(rem2 - {1'b0, den_reg}) : rem2[TW-1:0];

    // interpolation, one axis at a time
    assign d41        = (RW+1)'(frot_reg[axis_reg]) - (RW+1)'(brot_reg[axis_reg]);
    assign dmag       = d41[RW] ? (~d41 + 1'b1) : d41;
    assign lprod_calc = (RW+QW+1)'(dmag) * (RW+QW+1)'(quo_reg);
    assign lrnd       = lprod_reg + HALF_Q;
    assign adj        = lrnd[RW+QW:QW];
    assign back41     = (RW+1)'(brot_reg[axis_reg]);
    assign res41      = dneg_reg ? (back41 - $signed(adj)) : (back41 + $signed(adj));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            grii_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        grii_pkg::OP_SAMPLE:
                            state_next = samp_append ? grii_pkg::ST_SAMP_MUL : grii_pkg::ST_IDLE;
                        grii_pkg::OP_QUERY:
                            state_next = (count_reg < CW'(2)) ? grii_pkg::ST_OUT
                                                               : grii_pkg::ST_SRCH_RD;
                        default: state_next = grii_pkg::ST_IDLE;
                    endcase
                end
            end
            grii_pkg::ST_SAMP_MUL: state_next = grii_pkg::ST_SAMP_ADD;
            grii_pkg::ST_SAMP_ADD:
                state_next = (axis_reg == grii_pkg::LAST_AXIS) ? grii_pkg::ST_SAMP_WR
                                                               : grii_pkg::ST_SAMP_MUL;
            grii_pkg::ST_SAMP_WR:  state_next = grii_pkg::ST_IDLE;
            grii_pkg::ST_SRCH_RD:
                state_next = search_done ? grii_pkg::ST_FETCH_RD : grii_pkg::ST_SRCH_CMP;
            grii_pkg::ST_SRCH_CMP: state_next = grii_pkg::ST_SRCH_RD;
            grii_pkg::ST_FETCH_RD: state_next = grii_pkg::ST_FETCH_F;
            grii_pkg::ST_FETCH_F:
                state_next = front_direct ? grii_pkg::ST_OUT : grii_pkg::ST_FETCH_B;
            grii_pkg::ST_FETCH_B:  state_next = grii_pkg::ST_DIV;
            grii_pkg::ST_DIV:
                state_next = (step_reg == grii_pkg::STEP_W'(QW - 1)) ? grii_pkg::ST_LERP_MUL
                                                                     : grii_pkg::ST_DIV;
            grii_pkg::ST_LERP_MUL: state_next = grii_pkg::ST_LERP_ADD;
            grii_pkg::ST_LERP_ADD:
                state_next = (axis_reg == grii_pkg::LAST_AXIS) ? grii_pkg::ST_OUT
                                                               : grii_pkg::ST_LERP_MUL;
            grii_pkg::ST_OUT:
                state_next = out_free ? grii_pkg::ST_IDLE : grii_pkg::ST_OUT;
            default: state_next = grii_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine: queue pop and memory ports
    always_comb begin
        cmd_ready = (state_reg == grii_pkg::ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wtime = cmd_reg.time_stamp;
        ram_wrot  = {new_rot_reg[2], new_rot_reg[1], new_rot_reg[0]};
        ram_raddr = mid_sel;
        case (state_reg)
            grii_pkg::ST_IDLE: begin
                if (pop && (cmd.kind == grii_pkg::OP_SAMPLE) && samp_anchor) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wtime = in_t;
                    ram_wrot  = '0;
                end
            end
            grii_pkg::ST_SAMP_WR:  ram_we    = 1'b1;
            grii_pkg::ST_FETCH_RD: ram_raddr = f_reg;
            grii_pkg::ST_FETCH_F:  ram_raddr = f_reg - 1'b1;
            default: ram_raddr = mid_sel;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= grii_pkg::ST_IDLE;
            count_reg     <= '0;
            win_start_reg <= '0;
            win_end_reg   <= '0;
            sorted_reg    <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // result register: load a new result or retire an accepted one
            if ((state_reg == grii_pkg::ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                grii_pkg::ST_IDLE: begin
                    if (pop && (cmd.kind == grii_pkg::OP_START)) begin
                        win_start_reg <= in_t;
                        win_end_reg   <= cmd.scan_end_time;
                        count_reg     <= '0;
                    end
                    if (pop && (cmd.kind == grii_pkg::OP_SAMPLE) && samp_anchor) begin
                        count_reg  <= CW'(1);
                        sorted_reg <= 1'b1;
                    end
                end
                grii_pkg::ST_SAMP_WR: begin
                    count_reg <= count_reg + 1'b1;
                    if (cmd_reg.time_stamp < last_time_reg) begin
                        sorted_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            grii_pkg::ST_IDLE: begin
                axis_reg <= '0;
                if (pop) begin
                    cmd_reg       <= cmd;
                    dt_reg        <= (in_t > last_time_reg) ? (in_t - last_time_reg) : '0;
                    lo_reg        <= '0;
                    hi_reg        <= count_reg;
                    res_valid_reg <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        res_rot_reg[i] <= '0;
                    end
                end
                if (pop && (cmd.kind == grii_pkg::OP_SAMPLE) && samp_anchor) begin
                    last_time_reg <= in_t;
                    for (int i = 0; i < 3; i++) begin
                        last_rot_reg[i] <= '0;
                    end
                end
            end
            grii_pkg::ST_SAMP_MUL: begin
                phi_reg <= phi_calc;
                plo_reg <= plo_calc;
            end
            grii_pkg::ST_SAMP_ADD: begin
                new_rot_reg[axis_reg] <= sat_rot;
                axis_reg              <= axis_reg + 1'b1;
            end
            grii_pkg::ST_SAMP_WR: begin
                last_time_reg <= cmd_reg.time_stamp;
                for (int i = 0; i < 3; i++) begin
                    last_rot_reg[i] <= new_rot_reg[i];
                end
            end
            grii_pkg::ST_SRCH_RD: begin
                mid_reg <= mid_sel;
                f_reg   <= f_sel;
            end
            grii_pkg::ST_SRCH_CMP: begin
                if (ram_rtime >= cmd_reg.time_stamp) begin
                    hi_reg <= CW'(mid_reg);
                end else begin
                    lo_reg <= CW'(mid_reg) + 1'b1;
                end
            end
            grii_pkg::ST_FETCH_F: begin
                ftime_reg     <= ram_rtime;
                res_valid_reg <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    frot_reg[i]    <= rd_rot[i];
                    res_rot_reg[i] <= rd_rot[i];
                end
            end
            grii_pkg::ST_FETCH_B: begin
                den_reg  <= ftime_reg - ram_rtime;
                rem_reg  <= cmd_reg.time_stamp - ram_rtime;
                quo_reg  <= '0;
                step_reg <= '0;
                axis_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    brot_reg[i] <= rd_rot[i];
                end
            end
            grii_pkg::ST_DIV: begin
                rem_reg  <= rem_step;
                quo_reg  <= {quo_reg[QW-2:0], rem_ge};
                step_reg <= step_reg + 1'b1;
            end
            grii_pkg::ST_LERP_MUL: begin
                lprod_reg <= lprod_calc;
                dneg_reg  <= d41[RW];
            end
            grii_pkg::ST_LERP_ADD: begin
                res_rot_reg[axis_reg] <= res41[RW-1:0];
                axis_reg              <= axis_reg + 1'b1;
            end
            grii_pkg::ST_OUT: begin
                if (out_free) begin
                    m_rv_reg <= res_valid_reg;
                    for (int i = 0; i < 3; i++) begin
                        m_rot_reg[i] <= res_rot_reg[i];
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_rot_x          = m_rot_reg[0];
    assign m_rot_y          = m_rot_reg[1];
    assign m_rot_z          = m_rot_reg[2];
    assign m_rotation_valid = m_rv_reg;

endmodule

/* sv/grii_checker.sv */
`include "assert_macros.svh"

module grii_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [grii_pkg::ROT_W-1:0] m_rot_x,
    input logic signed [grii_pkg::ROT_W-1:0] m_rot_y,
    input logic signed [grii_pkg::ROT_W-1:0] m_rot_z,
    input logic                              m_rotation_valid
);

    // a stalled result stays offered
    `CHK_ASSERT(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    // a stalled result keeps its rotation
    `CHK_ASSERT(a_hold_data, aclk, aresetn, m_valid && !m_ready |=> $stable(m_rot_x) && $stable(m_rot_y) && $stable(m_rot_z) && $stable(m_rotation_valid), "result changed while stalled")

    // a result without a usable table carries zero rotation
    `CHK_ASSERT(a_zero_when_invalid, aclk, aresetn, m_valid && !m_rotation_valid |-> m_rot_x == 0 && m_rot_y == 0 && m_rot_z == 0, "nonzero rotation on invalid result")

    // nothing is offered right after reset
    `CHK_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result offered after reset")

endmodule

bind gyro_rotation_integrate_interpolate grii_checker u_grii_checker (.*);
